// File: design/rrc_pkg.sv
`timescale 1ns / 1ps
package rrc_pkg;

    localparam int VAL_W   = 20;
    localparam int DIV_W   = 11;
    localparam int TALLY_W = 11;
    localparam int SQ_W    = VAL_W + 1;
    localparam int DCNT_W  = $clog2(VAL_W + 1);

    localparam logic [VAL_W-1:0]   MAX_VALUE = 20'hFFFFF;
    localparam logic [VAL_W-1:0]   MAX_SPAN  = 20'd1024;
    localparam logic [TALLY_W-1:0] TALLY_MAX = 11'd1025;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
        logic             err;
    } rrc_item_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INIT = 6'b000010,
        S_TEST = 6'b000100,
        S_WDIV = 6'b001000,
        S_WMOD = 6'b010000,
        S_DONE = 6'b100000
    } rrc_state_t;

endpackage

// File: design/rrc_front.sv
`timescale 1ns / 1ps
module rrc_front
    import rrc_pkg::*;
(
    input  logic             start,
    input  logic [VAL_W-1:0] range_low,
    input  logic [VAL_W-1:0] range_high,
    input  logic             q_full,
    output logic             busy,
    output logic             push,
    output rrc_item_t        push_item
);

    logic [VAL_W-1:0] span;
    logic             bad;

    assign span = range_high - range_low;

    // low of zero, high above limit, reversed, or too wide
    assign bad = (range_low == '0) || (range_high > MAX_VALUE) ||
                 (range_low > range_high) || (span > MAX_SPAN);

    assign busy          = q_full;
    assign push          = start && !q_full;
    assign push_item.lo  = range_low;
    assign push_item.hi  = range_high;
    assign push_item.err = bad;

endmodule

// File: design/rrc_queue.sv
`timescale 1ns / 1ps
module rrc_queue
    import rrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  rrc_item_t push_item,
    input  logic      pop,
    output rrc_item_t pop_item,
    output logic      full,
    output logic      empty
);

    rrc_item_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// File: design/rrc_div.sv
`timescale 1ns / 1ps
module rrc_div
    import rrc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [VAL_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] remainder
);

    logic [VAL_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  dsr_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic [DIV_W-1:0]  rem_next;

    // one quotient bit per cycle, restoring
    assign trial    = {rem_reg, dvd_reg[VAL_W-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign rem_next = (trial >= {1'b0, dsr_reg}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

    assign done      = done_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[VAL_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= DCNT_W'(VAL_W);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// File: design/rrc_back.sv
`timescale 1ns / 1ps
module rrc_back
    import rrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  rrc_item_t          q_item,
    output logic               q_pop,
    output logic               div_start,
    output logic [VAL_W-1:0]   div_dividend,
    output logic [DIV_W-1:0]   div_divisor,
    input  logic               div_done,
    input  logic [DIV_W-1:0]   div_rem,
    output logic               done,
    output logic [TALLY_W-1:0] tally,
    output logic               range_error
);

    rrc_state_t         state_reg;
    logic [VAL_W-1:0]   n_reg;
    logic [VAL_W-1:0]   hi_reg;
    logic [DIV_W-1:0]   i_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [DIV_W-1:0]   cnt_reg;
    logic [TALLY_W-1:0] tally_reg;
    logic               done_reg;
    logic               err_reg;
    logic               sq_le_n;
    logic               sq_lt_n;

    assign sq_le_n = (sq_reg <= {1'b0, n_reg});
    assign sq_lt_n = (sq_reg <  {1'b0, n_reg});

    assign q_pop        = (state_reg == S_IDLE) && !q_empty;
    assign div_start    = (state_reg == S_TEST);
    assign div_dividend = n_reg;
    assign div_divisor  = sq_le_n ? i_reg : cnt_reg;

    assign done        = done_reg;
    assign tally       = tally_reg;
    assign range_error = err_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                n_reg  <= q_item.lo;
                hi_reg <= q_item.hi;
            end
            S_INIT:
            begin
                i_reg   <= DIV_W'(1);
                sq_reg  <= SQ_W'(1);
                cnt_reg <= '0;
            end
            S_WDIV:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        cnt_reg <= cnt_reg + (sq_lt_n ? DIV_W'(2) : DIV_W'(1));
                    end
                    i_reg  <= i_reg + DIV_W'(1);
                    sq_reg <= sq_reg + SQ_W'({i_reg, 1'b1});
                end
            end
            S_WMOD:
            begin
                if (div_done && (n_reg != hi_reg))
                begin
                    n_reg <= n_reg + VAL_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tally_reg <= '0;
            done_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        tally_reg <= '0;
                        if (q_item.err)
                        begin
                            done_reg <= 1'b1;
                            err_reg  <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_INIT;
                        end
                    end
                end
                S_INIT:
                begin
                    state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    state_reg <= sq_le_n ? S_WDIV : S_WMOD;
                end
                S_WDIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_TEST;
                    end
                end
                S_WMOD:
                begin
                    if (div_done)
                    begin
                        if (div_rem == '0)
                        begin
                            tally_reg <= tally_reg + TALLY_W'(1);
                        end
                        state_reg <= (n_reg == hi_reg) ? S_DONE : S_INIT;
                    end
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    err_reg   <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/refactorable_range_counter.sv
`timescale 1ns / 1ps
// channel  | handshake        | payload
// ---------+------------------+-------------------------------
// input    | start, busy      | range_low[19:0], range_high[19:0]
// result   | done (strobe)    | tally[10:0], range_error
//
// a range is taken when start is high and busy is low; up to two ranges wait in a queue
// each number n takes one divider pass per i with i*i <= n and one more by its divisor count on the
// shared divider, so a range runs those passes for each of its numbers in turn
// a bad range is flagged at transfer and gives its result, with no divider pass, at the queue head
// reset clears the queue and the back end; done is one cycle wide, the receiver cannot stall
module refactorable_range_counter
    import rrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VAL_W-1:0]   range_low,
    input  logic [VAL_W-1:0]   range_high,
    output logic               done,
    output logic [TALLY_W-1:0] tally,
    output logic               range_error
);

    logic             q_full;
    logic             q_empty;
    logic             push;
    rrc_item_t        push_item;
    logic             pop;
    rrc_item_t        pop_item;
    logic             div_start;
    logic [VAL_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_rem;

    rrc_front u_front (
        .start      (start),
        .range_low  (range_low),
        .range_high (range_high),
        .q_full     (q_full),
        .busy       (busy),
        .push       (push),
        .push_item  (push_item)
    );

    rrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    rrc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    rrc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_item       (pop_item),
        .q_pop        (pop),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_rem      (div_rem),
        .done         (done),
        .tally        (tally),
        .range_error  (range_error)
    );

endmodule

// File: design/rrc_checker.sv
`timescale 1ns / 1ps
module rrc_checker
    import rrc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [TALLY_W-1:0] tally,
    input logic               range_error
);

    a_err_zero_tally: assert property (@(posedge clk) disable iff (!rst_n)
        done && range_error |-> tally == '0)
        else $error("error result with nonzero tally");

    a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> tally <= TALLY_MAX)
        else $error("tally above span limit");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose without a transfer");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown({tally, range_error}))
        else $error("result fields unknown at done");

endmodule

bind refactorable_range_counter rrc_checker u_rrc_checker (.*);
